@@ design/lsi_pkg.sv @@
// Shared defaults, codes and the control word of the line and sphere intersection pipeline.
`default_nettype none

package lsi_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;

  localparam logic [1:0] HitsNone = 2'd0;
  localparam logic [1:0] HitsOne  = 2'd1;
  localparam logic [1:0] HitsTwo  = 2'd2;

  typedef struct packed {
    logic vld;
    logic miss;
    logic single;
  } lsi_ctl_t;

endpackage

`default_nettype wire

@@ design/lsi_wmul.sv @@
// Unsigned wide multiplier split into four registered partial products and a registered sum.
`default_nettype none

module lsi_wmul import lsi_pkg::*; #(
  parameter int unsigned N = 66
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N-1:0]   a_i,
  input  logic [N-1:0]   b_i,
  output logic [2*N-1:0] p_o
);

  localparam int unsigned LW  = (N + 1) / 2;
  localparam int unsigned HWd = N - LW;

  logic [2*LW-1:0]    ll_q;
  logic [LW+HWd-1:0]  lh_q;
  logic [LW+HWd-1:0]  hl_q;
  logic [2*HWd-1:0]   hh_q;
  logic [2*N-1:0]     p_q;
  logic [2*N-1:0]     p_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= (2*LW)'(a_i[LW-1:0]) * (2*LW)'(b_i[LW-1:0]);
      lh_q <= (LW+HWd)'(a_i[LW-1:0]) * (LW+HWd)'(b_i[N-1:LW]);
      hl_q <= (LW+HWd)'(a_i[N-1:LW]) * (LW+HWd)'(b_i[LW-1:0]);
      hh_q <= (2*HWd)'(a_i[N-1:LW]) * (2*HWd)'(b_i[N-1:LW]);
      p_q  <= p_d;
    end
  end

  always_comb begin
    p_d = (2*N)'(ll_q) + ((2*N)'(lh_q) << LW) + ((2*N)'(hl_q) << LW)
        + ((2*N)'(hh_q) << (2*LW));
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ design/lsi_sqrt_cell.sv @@
// One cell of the square root row: settles one result bit and hands its state on.
`default_nettype none

module lsi_sqrt_cell import lsi_pkg::*; #(
  parameter int unsigned DW   = 132,
  parameter int unsigned PW   = 1,
  parameter int unsigned STEP = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  lsi_ctl_t      ctl_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] root_i,
  input  logic [PW-1:0] pass_i,
  output lsi_ctl_t      ctl_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] root_o,
  output logic [PW-1:0] pass_o
);

  localparam logic [DW-1:0] Bit = {{(DW-1){1'b0}}, 1'b1} << (DW - 2 - 2 * STEP);

  lsi_ctl_t      ctl_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] root_q, root_d;
  logic [PW-1:0] pass_q;
  logic [DW-1:0] trial;
  logic          take;

  always_comb begin
    trial  = root_i + Bit;
    take   = rem_i >= trial;
    rem_d  = take ? rem_i - trial : rem_i;
    root_d = (root_i >> 1) + (take ? Bit : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      pass_q <= pass_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

@@ design/lsi_div_cell.sv @@
// One cell of the two-lane divider row: settles one quotient bit per lane.
`default_nettype none

module lsi_div_cell import lsi_pkg::*; #(
  parameter int unsigned DENW = 65,
  parameter int unsigned QW   = 32,
  parameter int unsigned PW   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  lsi_ctl_t             ctl_i,
  input  logic [DENW-1:0]      den_i,
  input  logic [1:0][DENW-1:0] rem_i,
  input  logic [1:0][QW-1:0]   low_i,
  input  logic [1:0][QW-1:0]   quo_i,
  input  logic [PW-1:0]        pass_i,
  output lsi_ctl_t             ctl_o,
  output logic [DENW-1:0]      den_o,
  output logic [1:0][DENW-1:0] rem_o,
  output logic [1:0][QW-1:0]   low_o,
  output logic [1:0][QW-1:0]   quo_o,
  output logic [PW-1:0]        pass_o
);

  lsi_ctl_t             ctl_q;
  logic [DENW-1:0]      den_q;
  logic [1:0][DENW-1:0] rem_q, rem_d;
  logic [1:0][QW-1:0]   low_q, low_d;
  logic [1:0][QW-1:0]   quo_q, quo_d;
  logic [PW-1:0]        pass_q;
  logic [1:0][DENW:0]   trial;
  logic [1:0]           take;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_i[l], low_i[l][QW-1]};
      take[l]  = trial[l] >= {1'b0, den_i};
      rem_d[l] = take[l] ? DENW'(trial[l] - {1'b0, den_i}) : DENW'(trial[l]);
      low_d[l] = low_i[l] << 1;
      quo_d[l] = {quo_i[l][QW-2:0], take[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      low_q  <= low_d;
      quo_q  <= quo_d;
      pass_q <= pass_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign low_o  = low_q;
  assign quo_o  = quo_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

@@ design/line_sphere_intersect.sv @@
// Top level of the pipelined line and sphere intersection unit.
//
// Channel   Direction  Handshake                 Payload
// in        slave      in_valid_i / in_stall_o   start, dir, center, sphere_radius
// out       master     out_valid_o / out_stall_i hit_count, t_far, t_near
//
// One item is accepted per cycle while in_stall_o is low.
// The square root row has 2*COORD_WIDTH+2 cells and the divider row has
// COORD_WIDTH cells. Reset clears every valid flag; payload registers are not reset.
// A stall on the output freezes the pipeline once the skid register holds an item.
`default_nettype none

module line_sphere_intersect import lsi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic        [COORD_WIDTH-2:0] sphere_radius_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [1:0]             hit_count_o,
  output logic signed [COORD_WIDTH-1:0] t_far_o,
  output logic signed [COORD_WIDTH-1:0] t_near_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned EW   = W + 1;
  localparam int unsigned AW   = 2 * W;
  localparam int unsigned HW   = 2 * W + 2;
  localparam int unsigned CW   = 2 * W + 3;
  localparam int unsigned MN   = 2 * W + 2;
  localparam int unsigned DSW  = 2 * MN + 1;
  localparam int unsigned DW   = 4 * W + 4;
  localparam int unsigned K    = DW / 2;
  localparam int unsigned SW   = 2 * W + 2;
  localparam int unsigned NSW  = 2 * W + 4;
  localparam int unsigned NMW  = NSW - 1 + F;
  localparam int unsigned DENW = 2 * W + 1;
  localparam int unsigned SPW  = AW + HW;

  localparam logic signed [W-1:0] TMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] TMin = {1'b1, {(W-1){1'b0}}};

  logic en;
  assign en = !in_stall_o;

  // Stage 0: operands and offsets.
  lsi_ctl_t               ctl0_q;
  logic signed [W-1:0]    dx_q [3];
  logic signed [EW-1:0]   ex_q [3];
  logic        [W-2:0]    r_q;

  // Stage 1: products.
  lsi_ctl_t               ctl1_q;
  logic signed [2*W-1:0]  dd_q [3];
  logic signed [2*W:0]    de_q [3];
  logic signed [2*W+1:0]  ee_q [3];
  logic        [2*W-3:0]  rr_q;

  // Stage 2: coefficients.
  lsi_ctl_t               ctl2_q;
  logic        [AW-1:0]   a2_q, a2_d;
  logic signed [HW-1:0]   h2_q, h2_d;
  logic signed [CW-1:0]   c2_q, c2_d;

  // Stage 3: magnitudes for the wide products.
  lsi_ctl_t               ctl3_q;
  logic        [MN-1:0]   ha_q, ca_q;
  logic                   cneg3_q;
  logic        [AW-1:0]   a3_q;
  logic signed [HW-1:0]   h3_q;

  lsi_ctl_t               ctl_m1_q, ctl_m2_q;
  logic        [AW-1:0]   a_m1_q, a_m2_q;
  logic signed [HW-1:0]   h_m1_q, h_m2_q;
  logic                   cneg_m1_q, cneg_m2_q;
  logic        [2*MN-1:0] hh_p, ac_p;

  logic signed [DSW-1:0]  dsum;

  lsi_ctl_t               sq_ctl  [K+1];
  logic        [DW-1:0]   sq_rem  [K+1];
  logic        [DW-1:0]   sq_root [K+1];
  logic        [SPW-1:0]  sq_pass [K+1];

  logic        [SW-1:0]   s_val;
  logic        [AW-1:0]   a_s;
  logic signed [HW-1:0]   h_s;

  lsi_ctl_t               ctl_p1_q;
  logic signed [NSW-1:0]  nf_q, nn_q;
  logic        [DENW-1:0] den_p1_q;

  lsi_ctl_t               dv_ctl  [W+1];
  logic [DENW-1:0]        dv_den  [W+1];
  logic [1:0][DENW-1:0]   dv_rem  [W+1];
  logic [1:0][W-1:0]      dv_low  [W+1];
  logic [1:0][W-1:0]      dv_quo  [W+1];
  logic [3:0]             dv_pass [W+1];

  logic [1:0][DENW-1:0]   rem_p2_d;
  logic [1:0][W-1:0]      low_p2_d;
  logic [3:0]             pass_p2_d;
  logic signed [NSW-1:0]  num_p2 [2];
  logic [NSW-2:0]         mag_p2 [2];
  logic [NMW-1:0]         scl_p2 [2];

  lsi_ctl_t               ctl_r_q;
  logic [1:0]             hit_r_q, hit_r_d;
  logic signed [W-1:0]    far_r_q, far_r_d, near_r_q, near_r_d;
  logic signed [W-1:0]    t_lane [2];

  logic                   push, pop;
  logic                   out_vld_q, skid_vld_q;
  logic [1:0]             out_hit_q, skid_hit_q;
  logic signed [W-1:0]    out_far_q, out_near_q, skid_far_q, skid_near_q;

  // Control words of the front stages, the stage after the square root row and the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q   <= '0;
      ctl1_q   <= '0;
      ctl2_q   <= '0;
      ctl3_q   <= '0;
      ctl_m1_q <= '0;
      ctl_m2_q <= '0;
      ctl_p1_q <= '0;
      ctl_r_q  <= '0;
    end else if (en) begin
      ctl0_q   <= '{vld: in_valid_i, miss: 1'b0, single: 1'b0};
      ctl1_q   <= ctl0_q;
      ctl2_q   <= '{vld: ctl1_q.vld, miss: (a2_d == '0), single: 1'b0};
      ctl3_q   <= ctl2_q;
      ctl_m1_q <= ctl3_q;
      ctl_m2_q <= ctl_m1_q;
      ctl_p1_q <= sq_ctl[K];
      ctl_r_q  <= dv_ctl[W];
    end
  end

  always_comb begin
    a2_d = $unsigned(dd_q[0]) + $unsigned(dd_q[1]) + $unsigned(dd_q[2]);
    h2_d = HW'(de_q[0]) + HW'(de_q[1]) + HW'(de_q[2]);
    c2_d = CW'(ee_q[0]) + CW'(ee_q[1]) + CW'(ee_q[2]) - $signed(CW'(rr_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q[0] <= dir_x_i;
      dx_q[1] <= dir_y_i;
      dx_q[2] <= dir_z_i;
      ex_q[0] <= EW'(start_x_i) - EW'(center_x_i);
      ex_q[1] <= EW'(start_y_i) - EW'(center_y_i);
      ex_q[2] <= EW'(start_z_i) - EW'(center_z_i);
      r_q     <= sphere_radius_i;

      for (int i = 0; i < 3; i++) begin
        dd_q[i] <= dx_q[i] * dx_q[i];
        de_q[i] <= dx_q[i] * ex_q[i];
        ee_q[i] <= ex_q[i] * ex_q[i];
      end
      rr_q <= r_q * r_q;

      a2_q <= a2_d;
      h2_q <= h2_d;
      c2_q <= c2_d;

      ha_q    <= h2_q[HW-1] ? MN'(-h2_q) : MN'(h2_q);
      ca_q    <= c2_q[CW-1] ? MN'(-c2_q) : MN'(c2_q);
      cneg3_q <= c2_q[CW-1];
      a3_q    <= a2_q;
      h3_q    <= h2_q;

      a_m1_q    <= a3_q;
      h_m1_q    <= h3_q;
      cneg_m1_q <= cneg3_q;
      a_m2_q    <= a_m1_q;
      h_m2_q    <= h_m1_q;
      cneg_m2_q <= cneg_m1_q;
    end
  end

  lsi_wmul #(.N(MN)) u_mul_hh (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ha_q),
    .b_i   (ha_q),
    .p_o   (hh_p)
  );

  lsi_wmul #(.N(MN)) u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (MN'(a3_q)),
    .b_i   (ca_q),
    .p_o   (ac_p)
  );

  // The discriminant is four times dsum.
  always_comb begin
    dsum = cneg_m2_q ? $signed(DSW'(hh_p) + DSW'(ac_p)) : $signed(DSW'(hh_p) - DSW'(ac_p));
  end

  lsi_ctl_t sq_ctl_q;
  logic [DW-1:0]  sq_rem_q;
  logic [SPW-1:0] sq_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ctl_q <= '0;
    end else if (en) begin
      sq_ctl_q <= '{vld: ctl_m2_q.vld, miss: ctl_m2_q.miss || dsum[DSW-1],
                    single: (dsum == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q  <= dsum[DSW-1] ? '0 : {dsum[DW-3:0], 2'b00};
      sq_pass_q <= {a_m2_q, h_m2_q};
    end
  end

  assign sq_ctl[0]  = sq_ctl_q;
  assign sq_rem[0]  = sq_rem_q;
  assign sq_root[0] = '0;
  assign sq_pass[0] = sq_pass_q;

  for (genvar g = 0; g < K; g++) begin : g_sqrt
    lsi_sqrt_cell #(.DW(DW), .PW(SPW), .STEP(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .pass_i (sq_pass[g]),
      .ctl_o  (sq_ctl[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .pass_o (sq_pass[g+1])
    );
  end

  assign s_val = sq_root[K][SW-1:0];
  assign a_s   = sq_pass[K][SPW-1:HW];
  assign h_s   = $signed(sq_pass[K][HW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nf_q     <= NSW'(s_val) - (NSW'(h_s) <<< 1);
      nn_q     <= -$signed(NSW'(s_val)) - (NSW'(h_s) <<< 1);
      den_p1_q <= {a_s, 1'b0};
    end
  end

  always_comb begin
    num_p2[0] = nf_q;
    num_p2[1] = nn_q;
    for (int l = 0; l < 2; l++) begin
      mag_p2[l]   = num_p2[l][NSW-1] ? (NSW-1)'(-num_p2[l]) : (NSW-1)'(num_p2[l]);
      scl_p2[l]   = {mag_p2[l], {F{1'b0}}};
      rem_p2_d[l] = DENW'(scl_p2[l][NMW-1:W]);
      low_p2_d[l] = scl_p2[l][W-1:0];
      pass_p2_d[2*l+1] = num_p2[l][NSW-1];
      pass_p2_d[2*l]   = NMW'(scl_p2[l][NMW-1:W]) >= NMW'(den_p1_q);
    end
  end

  lsi_ctl_t             dv_ctl_q;
  logic [DENW-1:0]      dv_den_q;
  logic [1:0][DENW-1:0] dv_rem_q;
  logic [1:0][W-1:0]    dv_low_q;
  logic [3:0]           dv_pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_ctl_q <= '0;
    end else if (en) begin
      dv_ctl_q <= ctl_p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_den_q  <= den_p1_q;
      dv_rem_q  <= rem_p2_d;
      dv_low_q  <= low_p2_d;
      dv_pass_q <= pass_p2_d;
    end
  end

  assign dv_ctl[0]  = dv_ctl_q;
  assign dv_den[0]  = dv_den_q;
  assign dv_rem[0]  = dv_rem_q;
  assign dv_low[0]  = dv_low_q;
  assign dv_quo[0]  = '0;
  assign dv_pass[0] = dv_pass_q;

  for (genvar g = 0; g < W; g++) begin : g_div
    lsi_div_cell #(.DENW(DENW), .QW(W), .PW(4)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dv_ctl[g]),
      .den_i  (dv_den[g]),
      .rem_i  (dv_rem[g]),
      .low_i  (dv_low[g]),
      .quo_i  (dv_quo[g]),
      .pass_i (dv_pass[g]),
      .ctl_o  (dv_ctl[g+1]),
      .den_o  (dv_den[g+1]),
      .rem_o  (dv_rem[g+1]),
      .low_o  (dv_low[g+1]),
      .quo_o  (dv_quo[g+1]),
      .pass_o (dv_pass[g+1])
    );
  end

  // Sign, saturation and the hit count.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!dv_pass[W][2*l+1]) begin
        t_lane[l] = (dv_pass[W][2*l] || dv_quo[W][l][W-1]) ? TMax : $signed(dv_quo[W][l]);
      end else if (dv_pass[W][2*l] || (dv_quo[W][l][W-1] && (|dv_quo[W][l][W-2:0]))) begin
        t_lane[l] = TMin;
      end else begin
        t_lane[l] = -$signed(dv_quo[W][l]);
      end
    end
    if (dv_ctl[W].miss) begin
      hit_r_d  = HitsNone;
      far_r_d  = '0;
      near_r_d = '0;
    end else begin
      hit_r_d  = dv_ctl[W].single ? HitsOne : HitsTwo;
      far_r_d  = t_lane[0];
      near_r_d = t_lane[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_r_q  <= hit_r_d;
      far_r_q  <= far_r_d;
      near_r_q <= near_r_d;
    end
  end

  // Output register with a skid entry behind it.
  assign push = en && ctl_r_q.vld;
  assign pop  = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_hit_q  <= skid_hit_q;
        out_far_q  <= skid_far_q;
        out_near_q <= skid_near_q;
      end else begin
        out_hit_q  <= hit_r_q;
        out_far_q  <= far_r_q;
        out_near_q <= near_r_q;
      end
    end else if (push) begin
      skid_hit_q  <= hit_r_q;
      skid_far_q  <= far_r_q;
      skid_near_q <= near_r_q;
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign hit_count_o = out_hit_q;
  assign t_far_o     = out_far_q;
  assign t_near_o    = out_near_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("Skid entry is full while the output register is empty.");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_count_o == HitsNone) |-> (t_far_o == '0 && t_near_o == '0))
    else $error("An item without hits carries nonzero parameters.");

  a_single_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_count_o == HitsOne) |-> (t_far_o == t_near_o))
    else $error("A tangent item carries two different parameters.");

  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_count_o == HitsTwo) |-> (t_far_o >= t_near_o))
    else $error("The far parameter is below the near parameter.");
`endif

endmodule

`default_nettype wire

@@ test/tb_line_sphere_intersect.sv @@
// Self-checking testbench of the line_sphere_intersect pipeline with random idling and stalls.
`timescale 1ns / 1ps

module tb_line_sphere_intersect;
  import lsi_pkg::*;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz;
    logic signed [31:0] dx, dy, dz;
    logic signed [31:0] cx, cy, cz;
    logic        [30:0] rad;
  } ray_t;

  typedef struct packed {
    logic        [1:0]  hits;
    logic signed [31:0] far_t;
    logic signed [31:0] near_t;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] hit_count;
  logic signed [31:0] t_far, t_near;
  ray_t cur_ray = '0;

  ray_t pending_rays[$];
  hit_t expected_hits[$];
  int total_items = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_miss = 0, n_tangent = 0, n_two = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  line_sphere_intersect dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .start_x_i      (cur_ray.sx),
    .start_y_i      (cur_ray.sy),
    .start_z_i      (cur_ray.sz),
    .dir_x_i        (cur_ray.dx),
    .dir_y_i        (cur_ray.dy),
    .dir_z_i        (cur_ray.dz),
    .center_x_i     (cur_ray.cx),
    .center_y_i     (cur_ray.cy),
    .center_z_i     (cur_ray.cz),
    .sphere_radius_i(cur_ray.rad),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_count_o    (hit_count),
    .t_far_o        (t_far),
    .t_near_o       (t_near)
  );

  function automatic logic signed [31:0] clamp_t(logic signed [255:0] v);
    logic signed [255:0] hi_lim;
    logic signed [255:0] lo_lim;
    hi_lim = 256'sh7fff_ffff;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return 32'sh7fff_ffff;
    if (v < lo_lim) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic hit_t solve_hits(ray_t q);
    logic signed [255:0] dv[3];
    logic signed [255:0] ev[3];
    logic signed [255:0] a, b, c, rr, disc, rem, root, bitv, den, nb;
    hit_t h;
    dv[0] = q.dx; dv[1] = q.dy; dv[2] = q.dz;
    ev[0] = q.sx; ev[1] = q.sy; ev[2] = q.sz;
    ev[0] = ev[0] - q.cx; ev[1] = ev[1] - q.cy; ev[2] = ev[2] - q.cz;
    a = 0; b = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      a = a + dv[i] * dv[i];
      b = b + dv[i] * ev[i];
      c = c + ev[i] * ev[i];
    end
    b = b * 2;
    rr = $signed({225'b0, q.rad});
    c = c - rr * rr;
    disc = b * b - 4 * a * c;
    h = '0;
    if (a == 0 || disc < 0) return h;
    rem = disc;
    root = 0;
    bitv = 256'sd1 <<< 254;
    for (int i = 0; i < 128; i++) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    den = a * 2;
    nb = -b;
    h.far_t = clamp_t(((nb + root) * 65536) / den);
    h.near_t = clamp_t(((nb - root) * 65536) / den);
    h.hits = (disc == 0) ? HitsOne : HitsTwo;
    return h;
  endfunction

  function automatic ray_t mk(int sx, int sy, int sz, int dx, int dy, int dz,
                              int cx, int cy, int cz, int rad);
    ray_t q;
    q.sx = sx; q.sy = sy; q.sz = sz;
    q.dx = dx; q.dy = dy; q.dz = dz;
    q.cx = cx; q.cy = cy; q.cz = cz;
    q.rad = rad[30:0];
    return q;
  endfunction

  function automatic int near_val();
    return int'($urandom_range(1 << 20)) - (1 << 19);
  endfunction

  function automatic int phase_of();
    return (n_accepted * 4) / (total_items + 1);
  endfunction

  function automatic int send_idle_pct();
    case (phase_of())
      1: return 68;
      3: return 14;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (phase_of())
      2: return 68;
      3: return 14;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t h;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        h = solve_hits(cur_ray);
        expected_hits.push_back(h);
        n_accepted++;
        if (h.hits == HitsNone) n_miss++;
        else if (h.hits == HitsOne) n_tangent++;
        else n_two++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_ray <= pending_rays.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t h;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_hits.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("Unexpected result: hits %0d far %0d near %0d",
                                       hit_count, t_far, t_near);
        end else begin
          h = expected_hits.pop_front();
          if (hit_count !== h.hits || t_far !== h.far_t || t_near !== h.near_t) begin
            n_errors++;
            if (n_errors <= 10)
              $display("Mismatch on result %0d: expected hits %0d far %0d near %0d, got %0d %0d %0d",
                       n_checked, h.hits, h.far_t, h.near_t, hit_count, t_far, t_near);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  initial begin
    int r, cx, cy, cz, sx;
    // One unit is 65536 raw.
    pending_rays.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 65536));
    pending_rays.push_back(mk(-5 << 16, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 65536));
    pending_rays.push_back(mk(-5 << 16, 1 << 16, 0, 1 << 16, 0, 0, 0, 0, 0, 65536));
    pending_rays.push_back(mk(-5 << 16, 3 << 16, 0, 1 << 16, 0, 0, 0, 0, 0, 65536));
    pending_rays.push_back(mk(0, 0, 0, 0, 1 << 15, 0, 0, 0, 0, 131072));
    pending_rays.push_back(mk(5 << 16, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 65536));
    pending_rays.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(mk(0, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(mk(0, 0, 0, 1, 0, 0, 32'h7fff_0000, 0, 0, 65536));
    pending_rays.push_back(mk(0, 0, 0, -1, 0, 0, 32'h7fff_0000, 0, 0, 65536));
    pending_rays.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    pending_rays.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_rays.push_back(mk(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    pending_rays.push_back(mk(32'h8000_0000, 0, 0, 1, 1, 1, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff));
    pending_rays.push_back(mk(-1, -1, -1, 3, -7, 11, 2, 5, -9, 1));
    for (int i = 0; i < 1100; i++) begin
      case ($urandom_range(9))
        0, 1: pending_rays.push_back(mk($urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom, $urandom));
        7: begin
          r = $urandom_range(1 << 20);
          cx = near_val(); cy = near_val(); cz = near_val(); sx = near_val();
          pending_rays.push_back(mk(sx, cy + r, cz, near_val(), 0, 0, cx, cy, cz, r));
        end
        8: pending_rays.push_back(mk($urandom, $urandom, $urandom, 0, 0, 0,
                                     $urandom, $urandom, $urandom, $urandom));
        9: pending_rays.push_back(mk(near_val(), near_val(), near_val(),
                                     $urandom_range(3) - 1, $urandom_range(3) - 1, 1,
                                     $urandom, $urandom, $urandom, $urandom));
        default: pending_rays.push_back(mk(near_val(), near_val(), near_val(),
                                           near_val(), near_val(), near_val(),
                                           near_val(), near_val(), near_val(),
                                           $urandom_range(1 << 20)));
      endcase
    end
    total_items = pending_rays.size();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_accepted < total_items || expected_hits.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    $display("Ran %0d items through four idle and stall phases.", n_accepted);
    $display("Expected outcomes: %0d misses, %0d tangent hits, %0d two-point hits.",
             n_miss, n_tangent, n_two);
    if (n_errors == 0) begin
      $display("line_sphere_intersect verification clean");
    end else begin
      $display("%0d mismatches in total.", n_errors);
      $display("line_sphere_intersect verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d results outstanding.", expected_hits.size());
    $display("line_sphere_intersect verification failed");
    $finish;
  end

endmodule
